[design/mwt_pkg.sv]
// Package with shared constants and types of the margin weight trainer.
`timescale 1ns / 1ps

package mwt_pkg;

  localparam int MAX_FEATURES = 64;
  localparam int FRAC_BITS    = 16;

  localparam int WEIGHT_W = 32;
  localparam int STEP_W   = 24;
  localparam int ROUNDS_W = 10;
  localparam int CNT_W    = $clog2(MAX_FEATURES + 1);
  localparam int ADDR_W   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int SCORE_W  = WEIGHT_W + CNT_W - 1;
  localparam int NTOL_W   = STEP_W + CNT_W;
  localparam int DELTA_W  = STEP_W + ROUNDS_W;
  localparam int SUM_W    = DELTA_W + 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = STEP_W;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROUNDS = 1'd1;

  localparam logic [STEP_W-1:0]   STEP_SIZE_RST  = 24'd65536;
  localparam logic [ROUNDS_W-1:0] MAX_ROUNDS_RST = 10'd16;

  typedef logic [STEP_W-1:0]   step_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [ROUNDS_W-1:0] rounds_t;

endpackage

[design/margin_weight_trainer_top.sv]
// Top level of the margin weight trainer: buffer, score loop and result sequencer.
//
//   channel | ports                                       | direction
//   input   | start, busy, in_weight, in_is_spam, in_last_in | in (start/busy handshake)
//   result  | out_valid, out_new_weight, out_rounds_done, out_last_out | out (one-cycle strobe)
//   config  | cfg_we, cfg_index, cfg_data                 | in (write only)
//
// A word that is not last is taken while idle and busy stays low.
// A last word with n stored weights and R rounds keeps busy high through
// a 24-step divider, one multiply, the round loop, then one RAM read and
// one result for each stored weight.
// Reset is synchronous, clears the count, score, label and out_valid, and loads the config defaults.
// The receiver cannot stall; each result word is shown for one cycle.
`timescale 1ns / 1ps

module margin_weight_trainer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [31:0]              in_weight,
  input  logic                            in_is_spam,
  input  logic                            in_last_in,
  output logic                            out_valid,
  output logic signed [31:0]              out_new_weight,
  output mwt_pkg::rounds_t                out_rounds_done,
  output logic                            out_last_out,
  input  logic                            cfg_we,
  input  logic [mwt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mwt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import mwt_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_READ  = 3'd4;
  localparam logic [2:0] ST_EMIT  = 3'd5;

  localparam logic signed [SCORE_W-1:0] ONE = SCORE_W'(1) << FRAC_BITS;
  localparam logic signed [SUM_W-1:0] W_MAX = SUM_W'(32'sh7fffffff);
  localparam logic signed [SUM_W-1:0] W_MIN = -SUM_W'(33'sh080000000);

  logic [2:0]                 state_r, state_nxt;
  step_t                      step_size_r;
  rounds_t                    max_rounds_r;
  cnt_t                       cnt_r, cnt_nxt;
  logic signed [SCORE_W-1:0]  score_r, score_nxt;
  logic                       label_r, label_nxt;
  step_t                      tol_r, tol_nxt;
  logic [NTOL_W-1:0]          ntol_r, ntol_nxt;
  rounds_t                    rounds_r, rounds_nxt;
  logic [DELTA_W-1:0]         dacc_r, dacc_nxt;
  cnt_t                       k_r, k_nxt;
  logic                       ov_r, ov_nxt;
  logic signed [31:0]         ow_r, ow_nxt;
  logic                       ol_r, ol_nxt;

  logic                       accept;
  logic                       store_en;
  logic                       div_start;
  logic                       div_done;
  step_t                      div_q;
  logic [WEIGHT_W-1:0]        rd_data;
  logic                       below;
  logic signed [SCORE_W-1:0]  ntol_s;
  logic signed [SUM_W-1:0]    delta_s;
  logic signed [SUM_W-1:0]    sum_w;

  assign accept   = start && (state_r == ST_IDLE);
  assign store_en = accept && (cnt_r < CNT_W'(MAX_FEATURES));
  assign busy     = state_r != ST_IDLE;

  assign ntol_s  = $signed({{(SCORE_W-NTOL_W){1'b0}}, ntol_r});
  assign below   = label_r ? (score_r < ONE) : (score_r > -ONE);
  assign delta_s = label_r ? $signed({2'b00, dacc_r}) : -$signed({2'b00, dacc_r});
  assign sum_w   = $signed({{(SUM_W-WEIGHT_W){rd_data[WEIGHT_W-1]}}, rd_data}) + delta_s;

  mwt_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (MAX_FEATURES)
  ) u_buf (
    .clk   (clk),
    .we    (store_en),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (in_weight),
    .raddr (k_r[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  mwt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (step_size_r),
    .divisor  (cnt_nxt),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    score_nxt  = score_r;
    label_nxt  = label_r;
    tol_nxt    = tol_r;
    ntol_nxt   = ntol_r;
    rounds_nxt = rounds_r;
    dacc_nxt   = dacc_r;
    k_nxt      = k_r;
    ov_nxt     = 1'b0;
    ow_nxt     = ow_r;
    ol_nxt     = ol_r;
    div_start  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          label_nxt = in_is_spam;
          if (store_en) begin
            cnt_nxt   = cnt_r + 1'b1;
            score_nxt = score_r + SCORE_W'(in_weight);
          end
          if (in_last_in) begin
            if (cnt_nxt == '0) begin
              score_nxt = '0;
            end else begin
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          tol_nxt   = div_q;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        ntol_nxt   = NTOL_W'(cnt_r) * NTOL_W'(tol_r);
        rounds_nxt = '0;
        dacc_nxt   = '0;
        state_nxt  = ST_ROUND;
      end
      ST_ROUND: begin
        if (below && (rounds_r < max_rounds_r)) begin
          score_nxt  = label_r ? (score_r + ntol_s) : (score_r - ntol_s);
          rounds_nxt = rounds_r + 1'b1;
          dacc_nxt   = dacc_r + DELTA_W'(tol_r);
        end else begin
          k_nxt     = '0;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        ov_nxt = 1'b1;
        priority if (sum_w > W_MAX) begin
          ow_nxt = 32'sh7fffffff;
        end else if (sum_w < W_MIN) begin
          ow_nxt = 32'sh80000000;
        end else begin
          ow_nxt = sum_w[31:0];
        end
        k_nxt = k_r + 1'b1;
        if (k_nxt == cnt_r) begin
          ol_nxt    = 1'b1;
          cnt_nxt   = '0;
          score_nxt = '0;
          state_nxt = ST_IDLE;
        end else begin
          ol_nxt    = 1'b0;
          state_nxt = ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_size_r  <= STEP_SIZE_RST;
      max_rounds_r <= MAX_ROUNDS_RST;
      cnt_r        <= '0;
      score_r      <= '0;
      label_r      <= 1'b0;
      ov_r         <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      score_r <= score_nxt;
      label_r <= label_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_STEP_SIZE:  step_size_r  <= cfg_data;
          CFG_MAX_ROUNDS: max_rounds_r <= cfg_data[ROUNDS_W-1:0];
          default: ;
        endcase
      end
    end
    tol_r    <= tol_nxt;
    ntol_r   <= ntol_nxt;
    rounds_r <= rounds_nxt;
    dacc_r   <= dacc_nxt;
    k_r      <= k_nxt;
    ow_r     <= ow_nxt;
    ol_r     <= ol_nxt;
  end

  assign out_valid       = ov_r;
  assign out_new_weight  = ow_r;
  assign out_rounds_done = rounds_r;
  assign out_last_out    = ol_r;

endmodule

[design/mwt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mwt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/mwt_div.sv]
// Iterative restoring divider that forms the per-feature step one bit a cycle.
`timescale 1ns / 1ps

module mwt_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  mwt_pkg::step_t dividend,
  input  mwt_pkg::cnt_t  divisor,
  output logic           done,
  output mwt_pkg::step_t quotient
);

  import mwt_pkg::*;

  localparam int REM_W = CNT_W + 1;
  localparam int STEPS_W = $clog2(STEP_W);

  logic               run_r, run_nxt;
  logic               done_r, done_nxt;
  logic [STEPS_W-1:0] cnt_r, cnt_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  step_t              quo_r, quo_nxt;
  cnt_t               div_r, div_nxt;
  logic [REM_W-1:0]   trial;
  logic               ge;

  assign trial = {rem_r[REM_W-2:0], quo_r[STEP_W-1]};
  assign ge    = trial >= {1'b0, div_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = STEPS_W'(STEP_W - 1);
      rem_nxt = '0;
      quo_nxt = dividend;
      div_nxt = divisor;
    end else if (run_r) begin
      rem_nxt = ge ? (trial - {1'b0, div_r}) : trial;
      quo_nxt = {quo_r[STEP_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
